FILE: design/lsrt_pkg.sv
// ----------------------------------------------------------------------------
// lsrt_pkg
// Shared types and constants of the link state route table.
// ----------------------------------------------------------------------------
package lsrt_pkg;

    // Mesh size and address widths
    localparam int MESH_SIZE  = 16;
    localparam int NODE_W     = $clog2(MESH_SIZE);
    localparam int PHYS_WIDTH = 8;
    localparam int CNT_W      = NODE_W + 1;

    // Distance that marks an unreached node, and the sequence window
    localparam logic [7:0] HOP_INF    = 8'd255;
    localparam logic [7:0] SEQ_WINDOW = 8'd128;

    // Actions carried on the input stream
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_LSE   = 3'd1;
    localparam logic [2:0] ACT_PING  = 3'd2;
    localparam logic [2:0] ACT_HOPQ  = 3'd3;
    localparam logic [2:0] ACT_ONQ   = 3'd4;
    localparam logic [2:0] ACT_NBQ   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
    localparam logic [1:0] REG_LS_LIFETIME = 2'd1;
    localparam logic [1:0] REG_NB_LIFETIME = 2'd2;
    localparam logic [1:0] REG_PERIOD      = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0] LS_LIFETIME_RST = 8'd60;
    localparam logic [7:0] NB_LIFETIME_RST = 8'd60;
    localparam logic [7:0] PERIOD_RST      = 8'd10;

    // One link state entry
    typedef struct packed {
        logic [MESH_SIZE-1:0]  links;
        logic [7:0]            seq;
        logic [7:0]            life;
    } link_entry_t;

    // One neighbour link entry
    typedef struct packed {
        logic [PHYS_WIDTH-1:0] phys;
        logic [7:0]            ttl;
    } neigh_entry_t;

endpackage

FILE: design/lsrt_ram.sv
// ----------------------------------------------------------------------------
// lsrt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lsrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/link_state_route_table_unit.sv
// ----------------------------------------------------------------------------
// link_state_route_table_unit
// Next-hop routing table for a mesh, with link state aging and route search.
// ----------------------------------------------------------------------------
// One transaction is handled at a time by a sequencer around two RAMs (link
// states and neighbour links, 16 entries each, one read and one write per
// cycle). Neighbour queries sweep the neighbour RAM, and a tick sweeps both
// RAMs; when the tick also recomputes routes, each settled node takes one RAM
// read, one relax and a minimum scan over all 16 entries, and a traceback
// then finds the first hop of every node. A finished result waits in an
// output register, and the next transaction is taken while it waits.
module link_state_route_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream; s_tdata from bit 0: elapsed_seconds, node_address,
    // sequence_value, listed_address, list_empty, phys_address, zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // s_tuser: action
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    // Result stream; m_tdata from bit 0: accepted, hop address, route_resolved,
    // answer, announce, recalculated, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import lsrt_pkg::*;

    // Sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_T_RD   = 5'd1;
    localparam logic [4:0] S_T_WR   = 5'd2;
    localparam logic [4:0] S_ME_RD  = 5'd3;
    localparam logic [4:0] S_ME_WR  = 5'd4;
    localparam logic [4:0] S_PER    = 5'd5;
    localparam logic [4:0] S_D_RD   = 5'd6;
    localparam logic [4:0] S_D_REL  = 5'd7;
    localparam logic [4:0] S_D_SCAN = 5'd8;
    localparam logic [4:0] S_B_INIT = 5'd9;
    localparam logic [4:0] S_B_WALK = 5'd10;
    localparam logic [4:0] S_B_HOP  = 5'd11;
    localparam logic [4:0] S_P_CHK  = 5'd12;
    localparam logic [4:0] S_G_WR   = 5'd13;
    localparam logic [4:0] S_Q_ON   = 5'd14;
    localparam logic [4:0] S_N_RD   = 5'd15;
    localparam logic [4:0] S_N_CHK  = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;

    localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(MESH_SIZE - 1);

    // Configuration registers
    logic [NODE_W-1:0] own_reg;
    logic [7:0]        ls_life_reg, nb_life_reg, period_reg;

    // Control registers
    logic [4:0]        state_reg, state_next;
    logic [NODE_W-1:0] idx_reg, idx_next;
    logic [NODE_W-1:0] walk_reg, walk_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] bidx_reg, bidx_next;
    logic [7:0]        cd_reg, cd_next;
    logic [7:0]        best_reg, best_next;
    logic [MESH_SIZE-1:0] pend_reg, pend_next;
    logic [MESH_SIZE-1:0] clr_reg, clr_next;
    logic [MESH_SIZE-1:0] lvalid_reg, lvalid_next;
    logic [MESH_SIZE-1:0] nvalid_reg, nvalid_next;
    logic [MESH_SIZE-1:0] done_reg, done_next;
    logic [MESH_SIZE-1:0] hopv_reg, hopv_next;
    logic              dirty_reg, dirty_next;
    logic [7:0]        pcount_reg, pcount_next;
    logic              lq_v_reg, nq_v_reg;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [7:0]            el_reg, el_next;
    logic [7:0]            node_reg, node_next;
    logic [7:0]            seq_reg, seq_next;
    logic [PHYS_WIDTH-1:0] phys_reg, phys_next;
    logic [MESH_SIZE-1:0]  links_reg, links_next;
    logic [7:0]            dist_reg [MESH_SIZE];
    logic [7:0]            dist_next [MESH_SIZE];
    logic [NODE_W-1:0]     prev_reg [MESH_SIZE];
    logic [NODE_W-1:0]     prev_next [MESH_SIZE];
    logic [PHYS_WIDTH-1:0] hop_reg [MESH_SIZE];
    logic [PHYS_WIDTH-1:0] hop_next [MESH_SIZE];
    logic                  r_acc_reg, r_acc_next;
    logic                  r_res_reg, r_res_next;
    logic                  r_ans_reg, r_ans_next;
    logic                  r_ann_reg, r_ann_next;
    logic                  r_rec_reg, r_rec_next;
    logic [PHYS_WIDTH-1:0] r_hop_reg, r_hop_next;
    logic [15:0]           out_data_reg, out_data_next;

    // RAM ports
    logic              ln_we, nb_we;
    logic [NODE_W-1:0] ln_waddr, ln_raddr, nb_waddr, nb_raddr;
    link_entry_t       ln_wdata, ln_rdata, lq;
    neigh_entry_t      nb_wdata, nb_rdata, nq;

    // Input fields
    logic [7:0]            in_el, in_node, in_seq, in_listed;
    logic                  in_empty;
    logic [PHYS_WIDTH-1:0] in_phys;

    assign in_el     = s_tdata[7:0];
    assign in_node   = s_tdata[15:8];
    assign in_seq    = s_tdata[23:16];
    assign in_listed = s_tdata[31:24];
    assign in_empty  = s_tdata[32];
    assign in_phys   = s_tdata[33 +: PHYS_WIDTH];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // An entry never written reads as its reset value of zero
    assign lq = lq_v_reg ? ln_rdata : '0;
    assign nq = nq_v_reg ? nb_rdata : '0;

    lsrt_ram #(.WIDTH($bits(link_entry_t)), .DEPTH(MESH_SIZE)) u_link_ram (
        .clk   (clk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (ln_wdata),
        .raddr (ln_raddr),
        .rdata (ln_rdata)
    );

    lsrt_ram #(.WIDTH($bits(neigh_entry_t)), .DEPTH(MESH_SIZE)) u_neigh_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr (nb_waddr),
        .wdata (nb_wdata),
        .raddr (nb_raddr),
        .rdata (nb_rdata)
    );

    // Sequencer and datapath next-state logic
    always_comb
    begin
        logic [MESH_SIZE-1:0]  pm;
        logic [8:0]            sum;
        logic [8:0]            sum2;
        logic [7:0]            diff;
        logic                  ok;
        logic                  lnk;
        logic                  cand;
        logic [7:0]            nbest;
        logic [NODE_W-1:0]     ncur;
        link_entry_t           lw;
        neigh_entry_t          nw;

        pm    = '0;
        sum   = '0;
        sum2  = '0;
        diff  = '0;
        ok    = 1'b0;
        lnk   = 1'b0;
        cand  = 1'b0;
        nbest = '0;
        ncur  = '0;
        lw    = lq;
        nw    = nq;

        state_next     = state_reg;
        idx_next       = idx_reg;
        walk_next      = walk_reg;
        steps_next     = steps_reg;
        cur_next       = cur_reg;
        bidx_next      = bidx_reg;
        cd_next        = cd_reg;
        best_next      = best_reg;
        pend_next      = pend_reg;
        clr_next       = clr_reg;
        lvalid_next    = lvalid_reg;
        nvalid_next    = nvalid_reg;
        done_next      = done_reg;
        hopv_next      = hopv_reg;
        dirty_next     = dirty_reg;
        pcount_next    = pcount_reg;
        el_next        = el_reg;
        node_next      = node_reg;
        seq_next       = seq_reg;
        phys_next      = phys_reg;
        links_next     = links_reg;
        dist_next      = dist_reg;
        prev_next      = prev_reg;
        hop_next       = hop_reg;
        r_acc_next     = r_acc_reg;
        r_res_next     = r_res_reg;
        r_ans_next     = r_ans_reg;
        r_ann_next     = r_ann_reg;
        r_rec_next     = r_rec_reg;
        r_hop_next     = r_hop_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;

        ln_we    = 1'b0;
        ln_waddr = '0;
        ln_wdata = lq;
        ln_raddr = '0;
        nb_we    = 1'b0;
        nb_waddr = '0;
        nb_wdata = nq;
        nb_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    el_next    = in_el;
                    node_next  = in_node;
                    seq_next   = in_seq;
                    phys_next  = in_phys;
                    r_acc_next = 1'b0;
                    r_res_next = 1'b0;
                    r_ans_next = 1'b0;
                    r_ann_next = 1'b0;
                    r_rec_next = 1'b0;
                    r_hop_next = '0;
                    state_next = S_FIN;
                    unique case (s_tuser)
                        ACT_TICK:
                        begin
                            idx_next   = '0;
                            clr_next   = '0;
                            state_next = S_T_RD;
                        end
                        ACT_LSE:
                        begin
                            pm = pend_reg;
                            if (!in_empty && in_listed[7:NODE_W] == '0)
                            begin
                                pm = pm | (MESH_SIZE'(1) << in_listed[NODE_W-1:0]);
                            end
                            if (s_tlast)
                            begin
                                pend_next  = '0;
                                links_next = pm;
                                if (in_node[7:NODE_W] == '0 &&
                                    in_node[NODE_W-1:0] != own_reg)
                                begin
                                    ln_raddr   = in_node[NODE_W-1:0];
                                    state_next = S_P_CHK;
                                end
                            end
                            else
                            begin
                                pend_next = pm;
                            end
                        end
                        ACT_PING:
                        begin
                            if (in_node[7:NODE_W] == '0)
                            begin
                                nb_we    = 1'b1;
                                nb_waddr = in_node[NODE_W-1:0];
                                nb_wdata = '{phys: in_phys, ttl: nb_life_reg};
                                nvalid_next[in_node[NODE_W-1:0]] = 1'b1;
                                ln_raddr   = own_reg;
                                state_next = S_G_WR;
                            end
                        end
                        ACT_HOPQ:
                        begin
                            if (in_node[7:NODE_W] == '0 && hopv_reg[in_node[NODE_W-1:0]])
                            begin
                                r_hop_next = hop_reg[in_node[NODE_W-1:0]];
                                r_res_next = 1'b1;
                            end
                        end
                        ACT_ONQ:
                        begin
                            if (in_node[7:NODE_W] == '0)
                            begin
                                if (in_node[NODE_W-1:0] == own_reg)
                                begin
                                    r_ans_next = 1'b1;
                                end
                                else
                                begin
                                    ln_raddr   = in_node[NODE_W-1:0];
                                    state_next = S_Q_ON;
                                end
                            end
                        end
                        ACT_NBQ:
                        begin
                            idx_next   = '0;
                            state_next = S_N_RD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // Aging sweep over both RAMs
            S_T_RD:
            begin
                ln_raddr   = idx_reg;
                nb_raddr   = idx_reg;
                state_next = S_T_WR;
            end
            S_T_WR:
            begin
                if (lq.life > el_reg)
                begin
                    lw.life = lq.life - el_reg;
                end
                else if (lq.life != '0)
                begin
                    lw.life    = '0;
                    dirty_next = 1'b1;
                end
                if (nq.ttl > el_reg)
                begin
                    nw.ttl = nq.ttl - el_reg;
                end
                else if (nq.ttl != '0)
                begin
                    nw.ttl            = '0;
                    clr_next[idx_reg] = 1'b1;
                    dirty_next        = 1'b1;
                end
                ln_we    = 1'b1;
                ln_waddr = idx_reg;
                ln_wdata = lw;
                nb_we    = 1'b1;
                nb_waddr = idx_reg;
                nb_wdata = nw;
                lvalid_next[idx_reg] = 1'b1;
                nvalid_next[idx_reg] = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_ME_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_T_RD;
                end
            end

            // Drop expired neighbours from the own link mask
            S_ME_RD:
            begin
                ln_raddr   = own_reg;
                state_next = S_ME_WR;
            end
            S_ME_WR:
            begin
                lw.links = lq.links & ~clr_reg;
                ln_we    = 1'b1;
                ln_waddr = own_reg;
                ln_wdata = lw;
                lvalid_next[own_reg] = 1'b1;
                state_next = S_PER;
            end

            // Announce period and route recalculation start
            S_PER:
            begin
                sum  = {1'b0, pcount_reg} + {1'b0, el_reg};
                sum2 = sum;
                state_next = S_FIN;
                if (sum >= {1'b0, period_reg})
                begin
                    sum2       = sum - {1'b0, period_reg};
                    r_ann_next = 1'b1;
                    if (dirty_reg)
                    begin
                        r_rec_next = 1'b1;
                        for (int n = 0; n < MESH_SIZE; n++)
                        begin
                            dist_next[n] = HOP_INF;
                            prev_next[n] = own_reg;
                        end
                        dist_next[own_reg] = '0;
                        done_next  = '0;
                        cur_next   = own_reg;
                        cd_next    = '0;
                        state_next = S_D_RD;
                    end
                end
                pcount_next = sum2[8] ? 8'd255 : sum2[7:0];
            end

            // Settle the current node and fetch its links
            S_D_RD:
            begin
                ln_raddr           = cur_reg;
                done_next[cur_reg] = 1'b1;
                state_next         = S_D_REL;
            end
            S_D_REL:
            begin
                lnk = (lq.life != '0) || (cur_reg == own_reg);
                for (int b = 0; b < MESH_SIZE; b++)
                begin
                    if (lnk && lq.links[b] && (cd_reg + 8'd1 < dist_reg[b]))
                    begin
                        dist_next[b] = cd_reg + 8'd1;
                        prev_next[b] = cur_reg;
                    end
                end
                best_next  = HOP_INF;
                bidx_next  = '0;
                idx_next   = '0;
                state_next = S_D_SCAN;
            end

            // Scan for the nearest unsettled node, one per cycle
            S_D_SCAN:
            begin
                cand  = !done_reg[idx_reg] && (dist_reg[idx_reg] < best_reg);
                nbest = cand ? dist_reg[idx_reg] : best_reg;
                ncur  = cand ? idx_reg : bidx_reg;
                best_next = nbest;
                bidx_next = ncur;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next = '0;
                    if (nbest == HOP_INF)
                    begin
                        state_next = S_B_INIT;
                    end
                    else
                    begin
                        cd_next    = nbest;
                        cur_next   = ncur;
                        state_next = S_D_RD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Trace back the first hop of every node
            S_B_INIT:
            begin
                if (idx_reg != own_reg && done_reg[idx_reg])
                begin
                    walk_next  = idx_reg;
                    steps_next = '0;
                    state_next = S_B_WALK;
                end
                else
                begin
                    hopv_next[idx_reg] = 1'b0;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_B_WALK:
            begin
                if (steps_reg < CNT_W'(MESH_SIZE) && prev_reg[walk_reg] != own_reg)
                begin
                    walk_next  = prev_reg[walk_reg];
                    steps_next = steps_reg + 1'b1;
                end
                else
                begin
                    nb_raddr   = walk_reg;
                    state_next = S_B_HOP;
                end
            end
            S_B_HOP:
            begin
                hop_next[idx_reg]  = nq.phys;
                hopv_next[idx_reg] = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_B_INIT;
                end
            end

            // Link state packet check and commit
            S_P_CHK:
            begin
                ok   = 1'b1;
                diff = seq_reg - lq.seq;
                if (lq.life != '0 && (diff == '0 || diff > SEQ_WINDOW))
                begin
                    ok = 1'b0;
                end
                if (ok)
                begin
                    lw.life  = ls_life_reg;
                    lw.seq   = seq_reg;
                    lw.links = links_reg;
                    if (links_reg != lq.links)
                    begin
                        dirty_next = 1'b1;
                    end
                    ln_we      = 1'b1;
                    ln_waddr   = node_reg[NODE_W-1:0];
                    ln_wdata   = lw;
                    lvalid_next[node_reg[NODE_W-1:0]] = 1'b1;
                    r_acc_next = 1'b1;
                end
                state_next = S_FIN;
            end

            // Ping response adds the neighbour to the own link mask
            S_G_WR:
            begin
                lw.links = lq.links | (MESH_SIZE'(1) << node_reg[NODE_W-1:0]);
                if (lw.links != lq.links)
                begin
                    ln_we      = 1'b1;
                    ln_waddr   = own_reg;
                    ln_wdata   = lw;
                    lvalid_next[own_reg] = 1'b1;
                    dirty_next = 1'b1;
                end
                state_next = S_FIN;
            end

            S_Q_ON:
            begin
                r_ans_next = (lq.life != '0);
                state_next = S_FIN;
            end

            // Neighbour query sweep
            S_N_RD:
            begin
                nb_raddr   = idx_reg;
                state_next = S_N_CHK;
            end
            S_N_CHK:
            begin
                if (nq.phys == phys_reg && nq.ttl != '0)
                begin
                    r_ans_next = 1'b1;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_N_RD;
                end
            end

            // Hand the result to the output register
            S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {3'b000, r_rec_reg, r_ann_reg, r_ans_reg,
                                      r_res_reg, r_hop_reg, r_acc_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg       <= '0;
            ls_life_reg   <= LS_LIFETIME_RST;
            nb_life_reg   <= NB_LIFETIME_RST;
            period_reg    <= PERIOD_RST;
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            walk_reg      <= '0;
            steps_reg     <= '0;
            cur_reg       <= '0;
            bidx_reg      <= '0;
            cd_reg        <= '0;
            best_reg      <= '0;
            pend_reg      <= '0;
            clr_reg       <= '0;
            lvalid_reg    <= '0;
            nvalid_reg    <= '0;
            done_reg      <= '0;
            hopv_reg      <= '0;
            dirty_reg     <= 1'b0;
            pcount_reg    <= '0;
            lq_v_reg      <= 1'b0;
            nq_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_OWN_ADDRESS: own_reg     <= cfg_data[NODE_W-1:0];
                    REG_LS_LIFETIME: ls_life_reg <= cfg_data;
                    REG_NB_LIFETIME: nb_life_reg <= cfg_data;
                    REG_PERIOD:      period_reg  <= cfg_data;
                    default:         own_reg     <= own_reg;
                endcase
            end
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            walk_reg      <= walk_next;
            steps_reg     <= steps_next;
            cur_reg       <= cur_next;
            bidx_reg      <= bidx_next;
            cd_reg        <= cd_next;
            best_reg      <= best_next;
            pend_reg      <= pend_next;
            clr_reg       <= clr_next;
            lvalid_reg    <= lvalid_next;
            nvalid_reg    <= nvalid_next;
            done_reg      <= done_next;
            hopv_reg      <= hopv_next;
            dirty_reg     <= dirty_next;
            pcount_reg    <= pcount_next;
            lq_v_reg      <= lvalid_reg[ln_raddr];
            nq_v_reg      <= nvalid_reg[nb_raddr];
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        el_reg       <= el_next;
        node_reg     <= node_next;
        seq_reg      <= seq_next;
        phys_reg     <= phys_next;
        links_reg    <= links_next;
        dist_reg     <= dist_next;
        prev_reg     <= prev_next;
        hop_reg      <= hop_next;
        r_acc_reg    <= r_acc_next;
        r_res_reg    <= r_res_next;
        r_ans_reg    <= r_ans_next;
        r_ann_reg    <= r_ann_next;
        r_rec_reg    <= r_rec_next;
        r_hop_reg    <= r_hop_next;
        out_data_reg <= out_data_next;
    end

    // Once the graph is marked changed it stays marked.
    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_reg |=> dirty_reg)
        else $error("graph changed flag cleared");

    // A recalculation is only reported together with an announcement.
    a_rec_with_ann: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[12]) |-> m_tdata[11])
        else $error("recalculated without announce");

    // A resolved route never comes with a packet accept or an answer.
    a_res_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[9]) |-> (!m_tdata[0] && !m_tdata[10]))
        else $error("route result mixed with other results");

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link state route table unit.
// ----------------------------------------------------------------------------
// Items wait in a queue that an initial block fills phase by phase. A clocked
// driver sends them on the input stream with random idle bursts. Each accepted
// transaction is run through a behavioral route table model, and the result it
// predicts is queued. A clocked monitor compares each result transaction with
// the oldest prediction, field by field. Configuration changes happen only
// between phases, once the table is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import lsrt_pkg::*;

    // One input item and one result item
    typedef struct {
        logic [2:0] act;
        logic [7:0] elapsed;
        logic [7:0] node;
        logic [7:0] seq;
        logic [7:0] listed;
        logic       empty;
        logic       pkt_last;
        logic [7:0] phys;
    } route_item_t;

    typedef struct {
        logic       acc;
        logic [7:0] hop;
        logic       res;
        logic       ans;
        logic       ann;
        logic       rec;
    } route_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    route_item_t   pending_items[$];
    route_result_t expected_results[$];
    route_item_t   cur_item;
    int            mismatch_count = 0;
    int            stall_cycles = 0;
    bit            steady = 1'b0;
    int            send_gap = 0;
    int            recv_gap = 0;

    // Predicted configuration and table state
    logic [3:0]  own_addr;
    logic [7:0]  ls_life;
    logic [7:0]  nb_life;
    logic [7:0]  period;
    logic [7:0]  ls_ttl[MESH_SIZE];
    logic [7:0]  ls_seq[MESH_SIZE];
    logic [15:0] ls_links[MESH_SIZE];
    logic [7:0]  nb_ttl[MESH_SIZE];
    logic [7:0]  nb_phys[MESH_SIZE];
    logic [7:0]  hop_phys[MESH_SIZE];
    logic        hop_ok[MESH_SIZE];
    logic        dirty;
    int          period_acc;
    logic [15:0] collect_mask;

    // Stimulus-side memory of the last sequence used per source
    logic [7:0]  last_seq_sent[MESH_SIZE];

    link_state_route_table_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Table model: reset and register writes
    task automatic table_reset();
        own_addr = '0;
        ls_life = LS_LIFETIME_RST;
        nb_life = NB_LIFETIME_RST;
        period = PERIOD_RST;
        for (int n = 0; n < MESH_SIZE; n++)
        begin
            ls_ttl[n] = '0;
            ls_seq[n] = '0;
            ls_links[n] = '0;
            nb_ttl[n] = '0;
            nb_phys[n] = '0;
            hop_phys[n] = '0;
            hop_ok[n] = 1'b0;
            last_seq_sent[n] = '0;
        end
        dirty = 1'b0;
        period_acc = 0;
        collect_mask = '0;
    endtask

    task automatic table_write(logic [1:0] idx, logic [7:0] val);
        case (idx)
            REG_OWN_ADDRESS: own_addr = val[3:0];
            REG_LS_LIFETIME: ls_life = val;
            REG_NB_LIFETIME: nb_life = val;
            REG_PERIOD:      period = val;
            default: ;
        endcase
    endtask

    function automatic bit has_link(int a, int b);
        if (ls_ttl[a] == 0 && a != int'(own_addr))
            return 1'b0;
        return ls_links[a][b];
    endfunction

    // Unit-weight shortest path from this node, then first-hop traceback
    task automatic rebuild_routes();
        int  hop_dist[MESH_SIZE];
        int  prev[MESH_SIZE];
        bit  settled[MESH_SIZE];
        int  me;
        int  cur;
        int  cd;
        int  walk;
        me = int'(own_addr);
        cur = me;
        cd = 0;
        for (int n = 0; n < MESH_SIZE; n++)
        begin
            hop_dist[n] = int'(HOP_INF);
            prev[n] = me;
            settled[n] = 1'b0;
        end
        hop_dist[me] = 0;
        do
        begin
            settled[cur] = 1'b1;
            for (int b = 0; b < MESH_SIZE; b++)
                if (has_link(cur, b) && cd + 1 < hop_dist[b])
                begin
                    hop_dist[b] = cd + 1;
                    prev[b] = cur;
                end
            cd = int'(HOP_INF);
            for (int n = 0; n < MESH_SIZE; n++)
                if (!settled[n] && hop_dist[n] < cd)
                begin
                    cd = hop_dist[n];
                    cur = n;
                end
        end
        while (cd != int'(HOP_INF));
        for (int n = 0; n < MESH_SIZE; n++)
        begin
            if (n != me && settled[n])
            begin
                walk = n;
                for (int s = 0; s < MESH_SIZE && prev[walk] != me; s++)
                    walk = prev[walk];
                hop_phys[n] = nb_phys[walk];
                hop_ok[n] = 1'b1;
            end
            else
                hop_ok[n] = 1'b0;
        end
    endtask

    // Apply one item to the table model and return its result
    task automatic table_step(input route_item_t it, output route_result_t r);
        int          sum;
        int          me;
        int          diff;
        bit          ok;
        logic [15:0] links;
        me = int'(own_addr);
        r = '{default: '0};
        case (it.act)
            ACT_TICK:
            begin
                for (int n = 0; n < MESH_SIZE; n++)
                begin
                    if (ls_ttl[n] > it.elapsed)
                        ls_ttl[n] = ls_ttl[n] - it.elapsed;
                    else if (ls_ttl[n] > 0)
                    begin
                        ls_ttl[n] = '0;
                        dirty = 1'b1;
                    end
                    if (nb_ttl[n] > it.elapsed)
                        nb_ttl[n] = nb_ttl[n] - it.elapsed;
                    else if (nb_ttl[n] > 0)
                    begin
                        nb_ttl[n] = '0;
                        ls_links[me][n] = 1'b0;
                        dirty = 1'b1;
                    end
                end
                sum = period_acc + int'(it.elapsed);
                if (sum >= int'(period))
                begin
                    sum -= int'(period);
                    if (dirty)
                    begin
                        rebuild_routes();
                        r.rec = 1'b1;
                    end
                    r.ann = 1'b1;
                end
                period_acc = (sum > 255) ? 255 : sum;
            end
            ACT_LSE:
            begin
                if (!it.empty && it.listed < MESH_SIZE)
                    collect_mask[it.listed] = 1'b1;
                if (it.pkt_last)
                begin
                    links = collect_mask;
                    collect_mask = '0;
                    ok = it.node < MESH_SIZE && int'(it.node) != me;
                    if (ok && ls_ttl[it.node] != 0)
                    begin
                        diff = int'(8'(it.seq - ls_seq[it.node]));
                        if (diff == 0 || diff > int'(SEQ_WINDOW))
                            ok = 1'b0;
                    end
                    if (ok)
                    begin
                        ls_ttl[it.node] = ls_life;
                        ls_seq[it.node] = it.seq;
                        if (links != ls_links[it.node])
                        begin
                            ls_links[it.node] = links;
                            dirty = 1'b1;
                        end
                        r.acc = 1'b1;
                    end
                end
            end
            ACT_PING:
            begin
                if (it.node < MESH_SIZE)
                begin
                    nb_ttl[it.node] = nb_life;
                    nb_phys[it.node] = it.phys;
                    if (!ls_links[me][it.node])
                    begin
                        ls_links[me][it.node] = 1'b1;
                        dirty = 1'b1;
                    end
                end
            end
            ACT_HOPQ:
            begin
                if (it.node < MESH_SIZE && hop_ok[it.node])
                begin
                    r.hop = hop_phys[it.node];
                    r.res = 1'b1;
                end
            end
            ACT_ONQ:
            begin
                if (it.node < MESH_SIZE)
                    r.ans = (int'(it.node) == me || ls_ttl[it.node] > 0);
            end
            ACT_NBQ:
            begin
                for (int n = 0; n < MESH_SIZE; n++)
                    if (nb_phys[n] == it.phys && nb_ttl[n] > 0)
                        r.ans = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Input driver
    always @(posedge clk)
    begin
        route_result_t r;
        route_item_t   it;
        logic          next_valid;
        next_valid = s_tvalid;
        if (s_tvalid && s_tready)
        begin
            table_step(cur_item, r);
            expected_results.push_back(r);
            next_valid = 1'b0;
        end
        if (!next_valid && rst_n)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                cur_item <= it;
                s_tdata <= {7'd0, it.phys, it.empty, it.listed, it.seq, it.node,
                            it.elapsed};
                s_tuser <= it.act;
                s_tlast <= it.pkt_last;
                next_valid = 1'b1;
                if (!steady && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 16);
            end
        end
        s_tvalid <= next_valid;
    end

    // Result monitor, receiver stalls and watchdog
    always @(posedge clk)
    begin
        route_result_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= 20000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", int'(m_tdata), 0);
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.acc)
                    report_mismatch("accepted", int'(m_tdata[0]), int'(want.acc));
                if (m_tdata[8:1] !== want.hop)
                    report_mismatch("hop address", int'(m_tdata[8:1]), int'(want.hop));
                if (m_tdata[9] !== want.res)
                    report_mismatch("route_resolved", int'(m_tdata[9]), int'(want.res));
                if (m_tdata[10] !== want.ans)
                    report_mismatch("answer", int'(m_tdata[10]), int'(want.ans));
                if (m_tdata[11] !== want.ann)
                    report_mismatch("announce", int'(m_tdata[11]), int'(want.ann));
                if (m_tdata[12] !== want.rec)
                    report_mismatch("recalculated", int'(m_tdata[12]), int'(want.rec));
                if (m_tdata[15:13] !== 3'd0)
                    report_mismatch("zero fill", int'(m_tdata[15:13]), 0);
            end
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (steady)
            m_tready <= 1'b1;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Stimulus helpers
    function automatic route_item_t mk(logic [2:0] act, logic [7:0] elapsed,
                                       logic [7:0] node, logic [7:0] seq,
                                       logic [7:0] listed, logic empty,
                                       logic pkt_last, logic [7:0] phys);
        route_item_t it;
        it.act = act;
        it.elapsed = elapsed;
        it.node = node;
        it.seq = seq;
        it.listed = listed;
        it.empty = empty;
        it.pkt_last = pkt_last;
        it.phys = phys;
        return it;
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] pick_node();
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(16, 255));
        return 8'($urandom_range(0, MESH_SIZE - 1));
    endfunction

    function automatic logic [7:0] pick_phys();
        if ($urandom_range(0, 3) == 0)
            return rnd8();
        return {$urandom_range(0, 1) ? 4'hF : 4'h0, 4'($urandom_range(0, 7))};
    endfunction

    // A link state packet with random content, mostly with a fresh sequence
    task automatic add_packet();
        logic [7:0] src;
        logic [7:0] sq;
        int         len;
        logic       emp;
        src = pick_node();
        if ($urandom_range(0, 4) == 0)
            sq = rnd8();
        else
            sq = last_seq_sent[src[3:0]] + 8'($urandom_range(1, 128));
        last_seq_sent[src[3:0]] = sq;
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
        begin
            emp = (len == 1 && $urandom_range(0, 3) == 0) || $urandom_range(0, 15) == 0;
            pending_items.push_back(mk(ACT_LSE, rnd8(),
                ($urandom_range(0, 7) == 0) ? rnd8() : src,
                ($urandom_range(0, 7) == 0) ? rnd8() : sq,
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                            : 8'($urandom_range(0, MESH_SIZE - 1)),
                emp, 1'b0, rnd8()));
        end
        pending_items[$].node = src;
        pending_items[$].seq = sq;
        pending_items[$].pkt_last = 1'b1;
    endtask

    // Adds about count input items; a packet counts with all its elements
    task automatic add_random(int count);
        int base;
        int kind;
        base = pending_items.size();
        while (pending_items.size() - base < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 20)
                pending_items.push_back(mk(ACT_TICK,
                    ($urandom_range(0, 9) == 0) ? rnd8() : 8'($urandom_range(0, 12)),
                    rnd8(), rnd8(), rnd8(), rbit(), rbit(), rnd8()));
            else if (kind < 50)
                add_packet();
            else if (kind < 65)
                pending_items.push_back(mk(ACT_PING, rnd8(), pick_node(),
                    rnd8(), rnd8(), rbit(), rbit(), pick_phys()));
            else if (kind < 97)
                pending_items.push_back(mk(3'($urandom_range(ACT_HOPQ, ACT_NBQ)),
                    rnd8(), pick_node(), rnd8(), rnd8(), rbit(), rbit(), pick_phys()));
            else
                pending_items.push_back(mk(3'($urandom_range(6, 7)), rnd8(),
                    rnd8(), rnd8(), rnd8(), rbit(), rbit(), rnd8()));
        end
    endtask

    // Wait until every item is sent and every result has come back
    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        table_write(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(logic [7:0] own, logic [7:0] lsl, logic [7:0] nbl,
                         logic [7:0] per);
        write_reg(REG_OWN_ADDRESS, own);
        write_reg(REG_LS_LIFETIME, lsl);
        write_reg(REG_NB_LIFETIME, nbl);
        write_reg(REG_PERIOD, per);
    endtask

    // Main sequence
    initial
    begin
        table_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part under reset settings
        pending_items.push_back(mk(ACT_ONQ, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_HOPQ, 0, 8'd255, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_PING, 0, 1, 0, 0, 0, 0, 8'hA5));
        pending_items.push_back(mk(ACT_PING, 0, 15, 0, 0, 0, 0, 8'hFF));
        pending_items.push_back(mk(ACT_PING, 0, 16, 0, 0, 0, 0, 8'h5A));
        pending_items.push_back(mk(ACT_LSE, 0, 1, 5, 2, 0, 0, 0));
        pending_items.push_back(mk(ACT_LSE, 0, 1, 5, 8'd200, 0, 0, 0));
        pending_items.push_back(mk(ACT_LSE, 0, 1, 5, 15, 0, 1, 0));
        // Replayed sequence and a sequence beyond the window are refused
        pending_items.push_back(mk(ACT_LSE, 0, 1, 5, 3, 0, 1, 0));
        pending_items.push_back(mk(ACT_LSE, 0, 1, 8'd134, 3, 0, 1, 0));
        pending_items.push_back(mk(ACT_LSE, 0, 1, 8'd133, 0, 1, 1, 0));
        // Bad sources: own address and out of range
        pending_items.push_back(mk(ACT_LSE, 0, 0, 1, 1, 0, 1, 0));
        pending_items.push_back(mk(ACT_LSE, 0, 8'd255, 8'd255, 8'd255, 1, 1, 8'hFF));
        pending_items.push_back(mk(ACT_TICK, 10, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_HOPQ, 0, 1, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_HOPQ, 0, 15, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_NBQ, 0, 0, 0, 0, 0, 0, 8'hFF));
        pending_items.push_back(mk(ACT_ONQ, 0, 1, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(3'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 8'hFF));
        pending_items.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
        // Everything expires, counter overflows and saturates
        pending_items.push_back(mk(ACT_TICK, 8'd255, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_TICK, 8'd255, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_NBQ, 0, 0, 0, 0, 0, 0, 8'hA5));
        drain();

        add_random(80);
        drain();

        setup(8'd5, 8'd255, 8'd255, 8'd1);
        add_random(70);
        drain();

        setup(8'd15, 8'd1, 8'd1, 8'd255);
        add_random(50);
        drain();

        // Zero lifetimes and a zero period
        setup(8'd9, 8'd0, 8'd0, 8'd0);
        add_random(40);
        drain();

        setup(8'd3, 8'd40, 8'd30, 8'd5);
        add_random(80);
        drain();

        steady = 1'b1;
        setup(8'd0, 8'd20, 8'd25, 8'd3);
        add_random(80);
        drain();
        repeat (700) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
